/* src/odch_pkg.sv */
package odch_pkg;

  // Configuration port layout.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ColsRegW = 11;
  localparam int unsigned RowsRegW = 13;

  localparam logic [CfgIdxW-1:0] REG_COLS = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ROWS = 1'b1;

  localparam logic [ColsRegW-1:0] COLS_RESET = 11'd1024;
  localparam logic [RowsRegW-1:0] ROWS_RESET = 13'd4096;

  // Request operation codes.
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Result constants.
  localparam logic [15:0] COST_ONE  = 16'd4096;
  localparam logic [15:0] WALL_COST = 16'd40960;
  localparam logic [7:0]  WALL_GREY = 8'd100;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;

  // Fixed-point constants for the colour scale.
  localparam logic [63:0]        PI_Q30  = 64'd3373259426;
  localparam logic signed [63:0] TWO_Q30 = 64'sd2147483648;

  typedef struct packed {
    logic [15:0] cost;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } heat_t;

  // Rounded 4096 * sqrt(d2 / (2 h^2)) by binary search; ties round up.
  function automatic logic [12:0] dist_scaled(input int unsigned d2, input int unsigned h);
    logic [63:0] lim;
    logic [63:0] h2;
    logic [63:0] t;
    logic [12:0] lo;
    logic [12:0] hi;
    logic [12:0] mid;
    lim = 64'(d2) << 25;
    h2  = 64'(h) * 64'(h);
    lo  = 13'd0;
    hi  = 13'd4096;
    for (int i = 0; i < 14; i++) begin
      if (lo < hi) begin
        mid = 13'((14'(lo) + 14'(hi) + 14'd1) >> 1);
        t   = (64'(mid) << 1) - 64'd1;
        if (t * t * h2 <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 13'd1;
        end
      end
    end
    return lo;
  endfunction

  // 1 - cos(pi*w/1024) in Q30 from a truncating Taylor series, w up to 512.
  function automatic logic signed [63:0] half_wave(input logic [9:0] w);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    th   = (64'(w) * PI_Q30) >> 10;
    th2  = (th * th) >> 30;
    term = th2 >> 1;
    sum  = $signed(term);
    for (int k = 0; k < 5; k++) begin
      term = (term * th2) >> 30;
      case (k)
        0:       term = term / 64'd12;
        1:       term = term / 64'd30;
        2:       term = term / 64'd56;
        3:       term = term / 64'd90;
        default: term = term / 64'd132;
      endcase
      if ((k & 1) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // Level of the rising or falling colour ramp for a cost value.
  function automatic logic [7:0] sweep_level(input logic [12:0] q);
    logic [11:0]        u;
    logic signed [63:0] f;
    logic [63:0]        p;
    u = {1'b0, q[10:0]};
    if (u > 12'd1024) begin
      u = 12'd2048 - u;
    end
    if (u <= 12'd512) begin
      f = half_wave(u[9:0]);
    end else begin
      f = TWO_Q30 - half_wave(10'(12'd1024 - u));
    end
    if (f < 0) begin
      f = 64'sd0;
    end
    if (f > TWO_Q30) begin
      f = TWO_Q30;
    end
    p = (64'(f) * 64'd255) >> 31;
    return p[7:0];
  endfunction

  // Cost and colour of a free cell whose nearest obstacle lies at squared distance d2.
  function automatic heat_t heat_entry(input int unsigned d2, input int unsigned h);
    heat_t       e;
    logic [12:0] q;
    logic [7:0]  c;
    q      = 13'd4096 - dist_scaled(d2, h);
    c      = sweep_level(q);
    e.cost = 16'(q);
    if (q >= 13'd4096) begin
      e.red = LEVEL_MAX; e.green = 8'd0; e.blue = 8'd0;
    end else if (q >= 13'd3072) begin
      e.red = LEVEL_MAX; e.green = c; e.blue = 8'd0;
    end else if (q >= 13'd2048) begin
      e.red = c; e.green = LEVEL_MAX; e.blue = 8'd0;
    end else if (q >= 13'd1024) begin
      e.red = 8'd0; e.green = LEVEL_MAX; e.blue = c;
    end else begin
      e.red = 8'd0; e.green = c; e.blue = LEVEL_MAX;
    end
    return e;
  endfunction

endpackage

/* src/odch_if.sv */
// Request channel: one occupancy cell or drain step.
interface odch_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [7:0] occupancy;

  modport source(output valid, output op, output occupancy, input ready);
  modport sink(input valid, input op, input occupancy, output ready);
endinterface

// Result channel: cost and heat-map colour of one cell.
interface odch_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cost;
  logic        is_wall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        frame_end;

  modport source(output valid, output cost, output is_wall, output red, output green,
                 output blue, output frame_end, input ready);
  modport sink(input valid, input cost, input is_wall, input red, input green,
               input blue, input frame_end, output ready);
endinterface

/* src/obstacle_distance_cost_heatmap.sv */
// Channel    Dir  Carries                                        Taken when
// req_i      in   op, occupancy                                  valid && ready
// res_o      out  cost, is_wall, red, green, blue, frame_end     valid && ready
// cfg        in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i high
//
// One request is taken every cycle while the result side keeps up.
// A cell's result leaves WINDOW_HALF rows and WINDOW_HALF requests after the cell itself,
// and is presented once that request has passed the queue, the three search stages and the
// lookup. The line memory takes one read and one write each cycle, so nothing throttles it.
// Reset clears all control state; the line memory needs no clearing pass.
// A stalled result fills the queue, and then requests are held off.
module obstacle_distance_cost_heatmap #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned WINDOW_HALF = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [odch_pkg::CfgDataW-1:0] cfg_data_i,
  odch_in_if.sink                       req_i,
  odch_out_if.source                    res_o
);

  localparam int unsigned N     = 2 * WINDOW_HALF + 1;
  localparam int unsigned EntW  = N * N + 1;
  localparam int unsigned Depth = 2;

  logic            q_push;
  logic [EntW-1:0] q_push_data;
  logic            q_ready;
  logic            q_valid;
  logic [EntW-1:0] q_data;
  logic            q_pop;

  // Front: counters, line memory and window.
  odch_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .WINDOW_HALF(WINDOW_HALF)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .push_o      (q_push),
    .push_data_o (q_push_data),
    .push_ready_i(q_ready)
  );

  // Queue of masked windows between the two halves.
  odch_fifo #(
    .WIDTH(EntW),
    .DEPTH(Depth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_push_data),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_data),
    .pop_i  (q_pop)
  );

  // Back: distance search, cost and colour.
  odch_back #(
    .WINDOW_HALF(WINDOW_HALF)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .data_i (q_data),
    .pop_o  (q_pop),
    .res_o  (res_o)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> q_ready)
    else $error("queue push while full");

  // A free cell never costs more than one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.is_wall |-> res_o.cost <= odch_pkg::COST_ONE)
    else $error("free cell cost out of range");

  // An obstacle result carries the wall cost and grey.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_wall |-> res_o.cost == odch_pkg::WALL_COST
      && res_o.red == odch_pkg::WALL_GREY && res_o.blue == odch_pkg::WALL_GREY)
    else $error("obstacle result malformed");

  // The back half pops the queue only while it holds an entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

/* src/odch_front.sv */
module odch_front #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned WINDOW_HALF = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [odch_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [odch_pkg::CfgDataW-1:0]    cfg_data_i,
  odch_in_if.sink                          req_i,
  output logic                             push_o,
  output logic [(2*WINDOW_HALF+1)*(2*WINDOW_HALF+1):0] push_data_o,
  input  logic                             push_ready_i
);

  localparam int unsigned N   = 2 * WINDOW_HALF + 1;
  localparam int unsigned MW  = 2 * WINDOW_HALF;
  localparam int unsigned AW  = $clog2(MAX_COLS);
  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned LW  = $clog2(WINDOW_HALF * MAX_COLS + WINDOW_HALF + 1);
  localparam int unsigned RMW = $clog2(MAX_ROWS + 2 * WINDOW_HALF + 1);
  localparam int unsigned CMW = $clog2(MAX_COLS + 2 * WINDOW_HALF + 1);

  // Configuration registers.
  logic [odch_pkg::ColsRegW-1:0] cfg_cols_q;
  logic [odch_pkg::RowsRegW-1:0] cfg_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= odch_pkg::COLS_RESET;
      cfg_rows_q <= odch_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        odch_pkg::REG_COLS: cfg_cols_q <= cfg_data_i[odch_pkg::ColsRegW-1:0];
        odch_pkg::REG_ROWS: cfg_rows_q <= cfg_data_i[odch_pkg::RowsRegW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range.
  logic [CW-1:0]  cfg_cols_eff;
  logic [RCW-1:0] cfg_rows_eff;
  logic [LW-1:0]  delay_eff;

  always_comb begin
    if (cfg_cols_q == '0) begin
      cfg_cols_eff = CW'(1);
    end else if (32'(cfg_cols_q) > 32'(MAX_COLS)) begin
      cfg_cols_eff = CW'(MAX_COLS);
    end else begin
      cfg_cols_eff = CW'(cfg_cols_q);
    end
    if (cfg_rows_q == '0) begin
      cfg_rows_eff = RCW'(1);
    end else if (32'(cfg_rows_q) > 32'(MAX_ROWS)) begin
      cfg_rows_eff = RCW'(MAX_ROWS);
    end else begin
      cfg_rows_eff = RCW'(cfg_rows_q);
    end
    delay_eff = LW'(32'(cfg_cols_eff) * 32'(WINDOW_HALF) + 32'(WINDOW_HALF));
  end

  // Position counters of the request stream and of the result stream.
  logic           start_q, start_d;
  logic [CW-1:0]  cur_cols_q, cur_cols_d;
  logic [RCW-1:0] cur_rows_q, cur_rows_d;
  logic [LW-1:0]  lead_q, lead_d;
  logic [AW-1:0]  in_col_q, in_col_d;
  logic [RW-1:0]  out_r_q, out_r_d;
  logic [AW-1:0]  out_c_q, out_c_d;

  logic          acc;
  logic          a_adv;
  logic          has_out;
  logic          fend;
  logic [CW-1:0] eff_cols;
  logic          cell_bit;
  logic [N-1:0]  rmask;
  logic [N-1:0]  cmask;

  assign acc      = req_i.valid && req_i.ready;
  assign cell_bit = (req_i.op == odch_pkg::OP_CELL) && (req_i.occupancy != '0);

  always_comb begin
    eff_cols = start_q ? cfg_cols_eff : cur_cols_q;
    has_out  = !start_q && (lead_q == '0);
    fend     = has_out && (out_r_q == RW'(cur_rows_q - RCW'(1)))
               && (out_c_q == AW'(cur_cols_q - CW'(1)));

    start_d    = start_q;
    cur_cols_d = cur_cols_q;
    cur_rows_d = cur_rows_q;
    lead_d     = lead_q;
    in_col_d   = in_col_q;
    out_r_d    = out_r_q;
    out_c_d    = out_c_q;

    if (acc) begin
      if (start_q) begin
        cur_cols_d = cfg_cols_eff;
        cur_rows_d = cfg_rows_eff;
        start_d    = 1'b0;
        lead_d     = delay_eff - LW'(1);
      end else if (lead_q != '0) begin
        lead_d = lead_q - LW'(1);
      end

      if (in_col_q == AW'(eff_cols - CW'(1))) begin
        in_col_d = '0;
      end else begin
        in_col_d = in_col_q + AW'(1);
      end

      if (has_out) begin
        if (fend) begin
          start_d  = 1'b1;
          in_col_d = '0;
          out_r_d  = '0;
          out_c_d  = '0;
        end else if (out_c_q == AW'(cur_cols_q - CW'(1))) begin
          out_c_d = '0;
          out_r_d = out_r_q + RW'(1);
        end else begin
          out_c_d = out_c_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 1'b1;
      cur_cols_q <= CW'(MAX_COLS);
      cur_rows_q <= RCW'(MAX_ROWS);
      lead_q     <= '0;
      in_col_q   <= '0;
      out_r_q    <= '0;
      out_c_q    <= '0;
    end else begin
      start_q    <= start_d;
      cur_cols_q <= cur_cols_d;
      cur_rows_q <= cur_rows_d;
      lead_q     <= lead_d;
      in_col_q   <= in_col_d;
      out_r_q    <= out_r_d;
      out_c_q    <= out_c_d;
    end
  end

  // Window rows and columns that fall inside the map for the result cell.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      rmask[k] = (RMW'(out_r_q) + RMW'(k) >= RMW'(WINDOW_HALF))
                 && (RMW'(out_r_q) + RMW'(k) < RMW'(cur_rows_q) + RMW'(WINDOW_HALF));
      cmask[k] = (CMW'(out_c_q) + CMW'(k) >= CMW'(WINDOW_HALF))
                 && (CMW'(out_c_q) + CMW'(k) < CMW'(cur_cols_q) + CMW'(WINDOW_HALF));
    end
  end

  // Line stage: the column history read from the line memory lands here.
  logic          a_valid_q;
  logic          a_bit_q;
  logic [AW-1:0] a_addr_q;
  logic          a_out_q;
  logic          a_fend_q;
  logic [N-1:0]  a_rmask_q;
  logic [N-1:0]  a_cmask_q;
  logic [MW-1:0] mem_q;
  logic          byp_q;
  logic [MW-1:0] byp_data_q;
  logic [N-1:0]  column;

  assign a_adv       = a_valid_q && (!a_out_q || push_ready_i);
  assign req_i.ready = !a_valid_q || a_adv;
  assign column      = {a_bit_q, (byp_q ? byp_data_q : mem_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_bit_q    <= cell_bit;
      a_addr_q   <= in_col_q;
      a_out_q    <= has_out;
      a_fend_q   <= fend;
      a_rmask_q  <= rmask;
      a_cmask_q  <= cmask;
      byp_q      <= a_adv && (a_addr_q == in_col_q);
      byp_data_q <= column[N-1:1];
    end
  end

  // Line memory: the previous rows of each column, oldest in the low bit.
  logic [MW-1:0] line_mem [MAX_COLS];

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      line_mem[a_addr_q] <= column[N-1:1];
    end
    if (acc) begin
      mem_q <= line_mem[in_col_q];
    end
  end

  // Window of columns, oldest at index zero; every step shifts one column in.
  logic [N-1:0] win_q  [N];
  logic [N-1:0] win_sh [N];

  always_comb begin
    for (int j = 0; j < N - 1; j++) begin
      win_sh[j] = win_q[j + 1];
    end
    win_sh[N-1] = column;
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      for (int j = 0; j < N; j++) begin
        win_q[j] <= win_sh[j];
      end
    end
  end

  // Masked window and frame-end flag go to the queue.
  always_comb begin
    for (int j = 0; j < N; j++) begin
      for (int k = 0; k < N; k++) begin
        push_data_o[j*N + k] = win_sh[j][k] & a_cmask_q[j] & a_rmask_q[k];
      end
    end
    push_data_o[N*N] = a_fend_q;
  end

  assign push_o = a_valid_q && a_out_q && push_ready_i;

endmodule

/* src/odch_fifo.sv */
module odch_fifo #(
  parameter int unsigned WIDTH = 442,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push;
  logic             do_pop;

  assign ready_o = (count_q != NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/odch_back.sv */
module odch_back #(
  parameter int unsigned WINDOW_HALF = 10
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic [(2*WINDOW_HALF+1)*(2*WINDOW_HALF+1):0] data_i,
  output logic                                         pop_o,
  odch_out_if.source                                   res_o
);

  localparam int unsigned N   = 2 * WINDOW_HALF + 1;
  localparam int unsigned Cap = 2 * WINDOW_HALF * WINDOW_HALF;
  localparam int unsigned DW  = $clog2(Cap + 1);
  localparam int unsigned NG  = (N + 7) / 8;

  logic en;

  assign en    = !res_o.valid || res_o.ready;
  assign pop_o = en && valid_i;

  // Cost and colour table indexed by squared distance.
  odch_pkg::heat_t lut [2**DW];

  for (genvar i = 0; i < 2**DW; i++) begin : g_lut
    localparam odch_pkg::heat_t Entry =
      odch_pkg::heat_entry((i <= Cap) ? i : Cap, WINDOW_HALF);
    assign lut[i] = Entry;
  end

  // Stage 1: nearest obstacle in each window row, as a squared distance.
  logic [DW-1:0] row_d2 [N];
  logic [DW-1:0] row_q  [N];
  logic          v1_q;
  logic          wall1_q;
  logic          fend1_q;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      row_d2[k] = DW'(Cap);
      for (int a = WINDOW_HALF; a >= 0; a--) begin
        if (data_i[(WINDOW_HALF - a)*N + k] | data_i[(WINDOW_HALF + a)*N + k]) begin
          row_d2[k] = DW'((k - WINDOW_HALF) * (k - WINDOW_HALF) + a * a);
        end
      end
    end
  end

  // Stage 2: minimum over groups of up to eight rows.
  logic [DW-1:0] grp_d2 [NG];
  logic [DW-1:0] grp_q  [NG];
  logic          v2_q;
  logic          wall2_q;
  logic          fend2_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d2[g] = DW'(Cap);
      for (int m = 0; m < 8; m++) begin
        if (g*8 + m < N) begin
          if (row_q[g*8 + m] < grp_d2[g]) begin
            grp_d2[g] = row_q[g*8 + m];
          end
        end
      end
    end
  end

  // Stage 3: overall minimum.
  logic [DW-1:0] min_d2;
  logic [DW-1:0] d2_q;
  logic          v3_q;
  logic          wall3_q;
  logic          fend3_q;

  always_comb begin
    min_d2 = DW'(Cap);
    for (int g = 0; g < NG; g++) begin
      if (grp_q[g] < min_d2) begin
        min_d2 = grp_q[g];
      end
    end
  end

  // Stage 4: table lookup, or the wall cost and grey for an obstacle, into the result register.
  logic        out_valid_q;
  logic [15:0] cost_q;
  logic        wall_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;
  logic        fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        row_q[k] <= row_d2[k];
      end
      wall1_q <= data_i[WINDOW_HALF*N + WINDOW_HALF];
      fend1_q <= data_i[N*N];

      for (int g = 0; g < NG; g++) begin
        grp_q[g] <= grp_d2[g];
      end
      wall2_q <= wall1_q;
      fend2_q <= fend1_q;

      d2_q    <= min_d2;
      wall3_q <= wall2_q;
      fend3_q <= fend2_q;

      wall_q <= wall3_q;
      fend_q <= fend3_q;
      if (wall3_q) begin
        cost_q  <= odch_pkg::WALL_COST;
        red_q   <= odch_pkg::WALL_GREY;
        green_q <= odch_pkg::WALL_GREY;
        blue_q  <= odch_pkg::WALL_GREY;
      end else begin
        cost_q  <= lut[d2_q].cost;
        red_q   <= lut[d2_q].red;
        green_q <= lut[d2_q].green;
        blue_q  <= lut[d2_q].blue;
      end
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.cost      = cost_q;
  assign res_o.is_wall   = wall_q;
  assign res_o.red       = red_q;
  assign res_o.green     = green_q;
  assign res_o.blue      = blue_q;
  assign res_o.frame_end = fend_q;

endmodule
